// File: design/bca_pkg.sv
// Package for the bitmap cell allocator: state, mode, status and register codes.
// Also holds the widths and reset values shared by the allocator.
// No dependencies.
package bca_pkg;

    // Cells covered by one word of the used-bit map
    localparam int WORD_W = 8;
    localparam int BIT_W  = 3;

    // Default capacity and register reset values
    localparam int                 MAX_CELLS_DEFAULT = 256;
    localparam int                 COUNT_RESET       = 256;
    localparam logic [15:0]        SIZE_RESET        = 16'd16;
    localparam logic [31:0]        BASE_RESET        = 32'd0;

    // Field widths fixed by the interface
    localparam int CFG_COUNT_W = 9;
    localparam int SIZE_W      = 16;
    localparam int ADDR_W      = 32;
    localparam int OUT_IDX_W   = 8;
    localparam int OUT_FREE_W  = 9;
    localparam int PADDR_W     = 4;

    // Request modes
    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_RANGE     = 2'd2;
    localparam logic [1:0] STAT_NOT_ALLOC = 2'd3;

    // Register indexes (word address bits of paddr)
    localparam logic [1:0] REG_NUM_CELLS    = 2'd0;
    localparam logic [1:0] REG_CELL_SIZE    = 2'd1;
    localparam logic [1:0] REG_BASE_ADDRESS = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPAN,
        ST_RANGE,
        ST_DIV,
        ST_MUL,
        ST_UPDATE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

// File: design/bitmap_cell_allocator.sv
// Next-fit allocator of fixed-size cells over a word-organised used-bit map.
// Depends on bca_pkg for codes, widths and reset values.
//
// Each transfer on the s_ channel is one request and produces exactly one transfer
// on the m_ channel, unless a cell-count write cuts the request short; requests are
// worked one at a time and s_ready is low while a request is in progress. A query or
// a rejected allocation goes straight to the result; a free checks its range first,
// and a free inside the region then finds its cell with the restoring divider that
// takes one quotient bit per cycle. An allocation marks its cell and then searches
// for the next free cell, with the map memory port reading one 8-cell word per
// cycle. A result still waiting in the output register holds the request back
// until it is taken. After reset and after every write of the cell-count register
// the map is cleared by a pass over every map word, during which no request is taken.
module bitmap_cell_allocator #(
    parameter int MAX_CELLS = bca_pkg::MAX_CELLS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bca_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // Request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_mode,
    input  logic [bca_pkg::ADDR_W-1:0]      s_free_address,
    // Result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_status,
    output logic [bca_pkg::ADDR_W-1:0]      m_cell_address,
    output logic [bca_pkg::OUT_IDX_W-1:0]   m_cell_index,
    output logic [bca_pkg::OUT_FREE_W-1:0]  m_free_cells_left,
    output logic                            m_no_free_cells
);

    localparam int IDX_W     = $clog2(MAX_CELLS);
    localparam int CNT_W     = $clog2(MAX_CELLS + 1);
    localparam int WORD_W    = bca_pkg::WORD_W;
    localparam int BIT_W     = bca_pkg::BIT_W;
    localparam int NUM_WORDS = (MAX_CELLS + WORD_W - 1) / WORD_W;
    localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int SIZE_W    = bca_pkg::SIZE_W;
    localparam int PROD_W    = CNT_W + SIZE_W;
    localparam int DV_W      = IDX_W + SIZE_W;
    localparam int STEP_W    = $clog2(IDX_W);
    localparam int RST_CNT   = (bca_pkg::COUNT_RESET > MAX_CELLS) ?
                               MAX_CELLS : bca_pkg::COUNT_RESET;

    // Configuration registers
    logic [CNT_W-1:0]           count_reg;
    logic [SIZE_W-1:0]          size_reg;
    logic [bca_pkg::ADDR_W-1:0] base_reg;

    // Allocator state
    logic [IDX_W-1:0]           next_free_reg;
    logic                       full_reg;
    logic [CNT_W-1:0]           free_count_reg;

    // Sequencer and working registers
    bca_pkg::state_t            state_reg, state_next;
    logic [WADDR_W-1:0]         clr_w_reg;
    logic [1:0]                 mode_reg;
    logic [1:0]                 res_status_reg;
    logic [bca_pkg::ADDR_W-1:0] res_addr_reg;
    logic [IDX_W-1:0]           res_idx_reg;
    logic [bca_pkg::ADDR_W-1:0] off_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic [DV_W-1:0]            rem_reg;
    logic [DV_W-1:0]            dvs_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [IDX_W-1:0]           c0_reg;

    // Scan pipeline: issue side and check side
    logic [WADDR_W-1:0]         iss_w_reg;
    logic                       iss_wrap_reg;
    logic                       iss_done_reg;
    logic                       chk_v_reg;
    logic [WADDR_W-1:0]         chk_w_reg;
    logic                       chk_wrap_reg;

    // Result register
    logic                       m_valid_reg;
    logic [1:0]                 m_status_reg;
    logic [bca_pkg::ADDR_W-1:0] m_addr_reg;
    logic [bca_pkg::OUT_IDX_W-1:0]  m_idx_reg;
    logic [bca_pkg::OUT_FREE_W-1:0] m_free_reg;
    logic                       m_full_reg;

    // Map memory
    logic [WORD_W-1:0]          map_mem [NUM_WORDS];
    logic [WORD_W-1:0]          rdata_reg;
    logic [WADDR_W-1:0]         mem_addr;
    logic                       mem_we;
    logic [WORD_W-1:0]          mem_wdata;

    // Combinational helpers
    logic                       cfg_we;
    logic                       count_we;
    logic [bca_pkg::CFG_COUNT_W-1:0] wr_cnt;
    logic [CNT_W-1:0]           wr_cnt_clamped;
    logic                       s_take;
    logic                       out_free;
    logic                       alloc_blocked;
    logic [CNT_W-1:0]           mul_a;
    logic [PROD_W-1:0]          mul_p;
    logic                       div_ge;
    logic [WADDR_W-1:0]         idx_word;
    logic [BIT_W-1:0]           idx_bit;
    logic                       idx_used;
    logic [IDX_W-1:0]           c0_calc;
    logic [WADDR_W-1:0]         w0;
    logic [WADDR_W-1:0]         last_word;
    logic [WORD_W-1:0]          hit;
    logic                       found;
    logic [BIT_W-1:0]           first_bit;
    logic                       scan_final;

    assign pready   = 1'b1;
    assign cfg_we   = psel & penable & pwrite & pready;
    assign count_we = cfg_we && (paddr[3:2] == bca_pkg::REG_NUM_CELLS);
    assign s_ready  = (state_reg == bca_pkg::ST_IDLE);
    assign s_take   = s_valid & s_ready;
    assign out_free = ~m_valid_reg | m_ready;

    // An allocation is refused when the map is full or the pointer lies outside
    assign alloc_blocked = full_reg || (CNT_W'(next_free_reg) >= count_reg);

    // Register read-back
    always_comb begin
        case (paddr[3:2])
            bca_pkg::REG_NUM_CELLS:    prdata = 32'(count_reg);
            bca_pkg::REG_CELL_SIZE:    prdata = 32'(size_reg);
            bca_pkg::REG_BASE_ADDRESS: prdata = base_reg;
            default:                   prdata = 32'd0;
        endcase
    end

    // Count write is clamped into 1..MAX_CELLS
    assign wr_cnt = pwdata[bca_pkg::CFG_COUNT_W-1:0];
    always_comb begin
        if (wr_cnt == '0) begin
            wr_cnt_clamped = CNT_W'(1);
        end else if (32'(wr_cnt) > 32'(MAX_CELLS)) begin
            wr_cnt_clamped = CNT_W'(MAX_CELLS);
        end else begin
            wr_cnt_clamped = CNT_W'(wr_cnt);
        end
    end

    // Shared multiplier: region span for a free, cell offset for an address
    assign mul_a = (state_reg == bca_pkg::ST_SPAN) ? count_reg : CNT_W'(res_idx_reg);
    assign mul_p = mul_a * size_reg;

    // Divider compare for the current quotient bit
    assign div_ge = (rem_reg >= dvs_reg);

    // Position of the requested cell within the map
    assign idx_word = WADDR_W'(res_idx_reg >> BIT_W);
    assign idx_bit  = res_idx_reg[BIT_W-1:0];
    assign idx_used = rdata_reg[idx_bit];

    // Start of the circular search: the cell after the one just taken
    assign c0_calc   = (CNT_W'(res_idx_reg) + CNT_W'(1) >= count_reg) ?
                       '0 : IDX_W'(res_idx_reg + IDX_W'(1));
    assign w0        = WADDR_W'(c0_reg >> BIT_W);
    assign last_word = WADDR_W'((count_reg - CNT_W'(1)) >> BIT_W);

    // Free cells in the checked word, limited to the region and, on the
    // first pass, to cells at or after the start of the search
    always_comb begin
        logic [WADDR_W+BIT_W-1:0] cell_pos;
        for (int b = 0; b < WORD_W; b++) begin
            cell_pos = {chk_w_reg, BIT_W'(b)};
            hit[b]   = ~rdata_reg[b] && (32'(cell_pos) < 32'(count_reg)) &&
                       (chk_wrap_reg || (32'(cell_pos) >= 32'(c0_reg)));
        end
    end

    // Lowest free cell in the word
    always_comb begin
        first_bit = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (hit[b]) begin
                first_bit = BIT_W'(b);
            end
        end
    end
    assign found      = chk_v_reg & (|hit);
    assign scan_final = chk_v_reg & chk_wrap_reg & (chk_w_reg == w0);

    // Sequencer: next state and memory port control
    always_comb begin
        state_next = state_reg;
        mem_addr   = iss_w_reg;
        mem_we     = 1'b0;
        mem_wdata  = '0;
        case (state_reg)
            bca_pkg::ST_CLEAR: begin
                mem_addr = clr_w_reg;
                mem_we   = 1'b1;
                if (32'(clr_w_reg) == 32'(NUM_WORDS - 1)) begin
                    state_next = bca_pkg::ST_IDLE;
                end
            end
            bca_pkg::ST_IDLE: begin
                if (s_take) begin
                    case (s_mode)
                        bca_pkg::MODE_ALLOC: begin
                            if (alloc_blocked) begin
                                state_next = bca_pkg::ST_DONE;
                            end else begin
                                state_next = bca_pkg::ST_MUL;
                            end
                        end
                        bca_pkg::MODE_FREE: state_next = bca_pkg::ST_SPAN;
                        default:            state_next = bca_pkg::ST_DONE;
                    endcase
                end
            end
            bca_pkg::ST_SPAN: begin
                state_next = bca_pkg::ST_RANGE;
            end
            bca_pkg::ST_RANGE: begin
                if (off_reg >= 32'(prod_reg)) begin
                    state_next = bca_pkg::ST_DONE;
                end else begin
                    state_next = bca_pkg::ST_DIV;
                end
            end
            bca_pkg::ST_DIV: begin
                if (step_reg == '0) begin
                    state_next = bca_pkg::ST_MUL;
                end
            end
            bca_pkg::ST_MUL: begin
                mem_addr   = idx_word;
                state_next = bca_pkg::ST_UPDATE;
            end
            bca_pkg::ST_UPDATE: begin
                mem_addr  = idx_word;
                mem_wdata = rdata_reg;
                if (mode_reg == bca_pkg::MODE_ALLOC) begin
                    mem_we             = 1'b1;
                    mem_wdata[idx_bit] = 1'b1;
                    state_next         = bca_pkg::ST_SCAN;
                end else begin
                    mem_we             = idx_used;
                    mem_wdata[idx_bit] = 1'b0;
                    state_next         = bca_pkg::ST_DONE;
                end
            end
            bca_pkg::ST_SCAN: begin
                mem_addr = iss_w_reg;
                if (found || scan_final) begin
                    state_next = bca_pkg::ST_DONE;
                end
            end
            bca_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = bca_pkg::ST_IDLE;
                end
            end
            default: state_next = bca_pkg::ST_IDLE;
        endcase
        // A new cell count restarts the clearing pass
        if (count_we) begin
            state_next = bca_pkg::ST_CLEAR;
        end
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bca_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Map memory, one word read and, when enabled, written per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= map_mem[mem_addr];
    end

    // Configuration and allocator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= CNT_W'(RST_CNT);
            size_reg       <= bca_pkg::SIZE_RESET;
            base_reg       <= bca_pkg::BASE_RESET;
            next_free_reg  <= '0;
            full_reg       <= 1'b0;
            free_count_reg <= CNT_W'(RST_CNT);
            clr_w_reg      <= '0;
        end else if (count_we) begin
            // A new cell count empties the map
            count_reg      <= wr_cnt_clamped;
            free_count_reg <= wr_cnt_clamped;
            next_free_reg  <= '0;
            full_reg       <= 1'b0;
            clr_w_reg      <= '0;
        end else begin
            if (state_reg == bca_pkg::ST_CLEAR) begin
                clr_w_reg <= clr_w_reg + WADDR_W'(1);
            end
            // Taking or releasing a cell
            if (state_reg == bca_pkg::ST_UPDATE) begin
                if (mode_reg == bca_pkg::MODE_ALLOC) begin
                    if (free_count_reg != '0) begin
                        free_count_reg <= free_count_reg - CNT_W'(1);
                    end
                    full_reg <= 1'b1;
                end else if (idx_used) begin
                    free_count_reg <= free_count_reg + CNT_W'(1);
                    if (full_reg) begin
                        next_free_reg <= res_idx_reg;
                    end
                    full_reg <= 1'b0;
                end
            end
            // Search found the next free cell
            if (state_reg == bca_pkg::ST_SCAN && found) begin
                next_free_reg <= IDX_W'({chk_w_reg, first_bit});
                full_reg      <= 1'b0;
            end
            if (cfg_we) begin
                case (paddr[3:2])
                    bca_pkg::REG_CELL_SIZE: begin
                        size_reg <= (pwdata[SIZE_W-1:0] == '0) ?
                                    SIZE_W'(1) : pwdata[SIZE_W-1:0];
                    end
                    bca_pkg::REG_BASE_ADDRESS: begin
                        base_reg <= pwdata;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Request working registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            bca_pkg::ST_IDLE: begin
                if (s_take) begin
                    mode_reg     <= s_mode;
                    off_reg      <= s_free_address - base_reg;
                    res_addr_reg <= '0;
                    if (s_mode == bca_pkg::MODE_ALLOC && alloc_blocked) begin
                        res_status_reg <= bca_pkg::STAT_FULL;
                    end else begin
                        res_status_reg <= bca_pkg::STAT_OK;
                    end
                    if (s_mode == bca_pkg::MODE_ALLOC && !alloc_blocked) begin
                        res_idx_reg <= next_free_reg;
                    end else begin
                        res_idx_reg <= '0;
                    end
                end
            end
            bca_pkg::ST_SPAN: begin
                prod_reg <= mul_p;
            end
            bca_pkg::ST_RANGE: begin
                if (off_reg >= 32'(prod_reg)) begin
                    res_status_reg <= bca_pkg::STAT_RANGE;
                end
                rem_reg  <= DV_W'(off_reg);
                dvs_reg  <= DV_W'(size_reg) << (IDX_W - 1);
                step_reg <= STEP_W'(IDX_W - 1);
            end
            // Restoring division, one quotient bit per cycle
            bca_pkg::ST_DIV: begin
                if (div_ge) begin
                    rem_reg <= rem_reg - dvs_reg;
                end
                dvs_reg     <= dvs_reg >> 1;
                res_idx_reg <= IDX_W'({res_idx_reg, div_ge});
                step_reg    <= step_reg - STEP_W'(1);
            end
            bca_pkg::ST_MUL: begin
                prod_reg <= mul_p;
            end
            bca_pkg::ST_UPDATE: begin
                res_addr_reg <= base_reg + 32'(prod_reg);
                if (mode_reg != bca_pkg::MODE_ALLOC && !idx_used) begin
                    res_status_reg <= bca_pkg::STAT_NOT_ALLOC;
                end
                c0_reg <= c0_calc;
            end
            default: ;
        endcase
    end

    // Search pipeline: one word issued and one word checked per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chk_v_reg    <= 1'b0;
            iss_done_reg <= 1'b1;
        end else if (state_reg == bca_pkg::ST_UPDATE) begin
            iss_w_reg    <= WADDR_W'(c0_calc >> BIT_W);
            iss_wrap_reg <= 1'b0;
            iss_done_reg <= 1'b0;
            chk_v_reg    <= 1'b0;
        end else if (state_reg == bca_pkg::ST_SCAN) begin
            chk_v_reg    <= ~iss_done_reg;
            chk_w_reg    <= iss_w_reg;
            chk_wrap_reg <= iss_wrap_reg;
            if (!iss_done_reg) begin
                if (!iss_wrap_reg) begin
                    if (iss_w_reg == last_word) begin
                        iss_w_reg    <= '0;
                        iss_wrap_reg <= 1'b1;
                    end else begin
                        iss_w_reg <= iss_w_reg + WADDR_W'(1);
                    end
                end else if (iss_w_reg == w0) begin
                    iss_done_reg <= 1'b1;
                end else begin
                    iss_w_reg <= iss_w_reg + WADDR_W'(1);
                end
            end
        end else begin
            chk_v_reg <= 1'b0;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == bca_pkg::ST_DONE && out_free) begin
            m_valid_reg  <= 1'b1;
            m_status_reg <= res_status_reg;
            m_addr_reg   <= res_addr_reg;
            m_idx_reg    <= bca_pkg::OUT_IDX_W'(res_idx_reg);
            m_free_reg   <= bca_pkg::OUT_FREE_W'(free_count_reg);
            m_full_reg   <= full_reg;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_cell_address    = m_addr_reg;
    assign m_cell_index      = m_idx_reg;
    assign m_free_cells_left = m_free_reg;
    assign m_no_free_cells   = m_full_reg;

endmodule
